### design/cbez_pkg.sv
// shared constants and types for the cubic bezier point evaluator
package cbez_pkg;

  localparam int COORD_BITS_DEF      = 16;
  localparam int PARAM_FRAC_BITS_DEF = 16;

  localparam int NUM_CTRL_POINTS = 4;
  localparam int NUM_AXES        = 3;
  localparam int REG_W           = 48;
  localparam int CFG_IDX_W       = 8;
  localparam int PARAM_T_W       = 17;
  localparam int POINT_W         = 16;
  localparam int IN_TDATA_W      = 24;
  localparam int OUT_TDATA_W     = 48;

  // per-stage load enables for the coordinate datapath
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } cbez_ld_t;

endpackage

### design/cbez_axis.sv
// one coordinate of the curve point: three de casteljau lerp levels and rounding
module cbez_axis import cbez_pkg::*; #(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  cbez_ld_t                     ld_i,
  input  logic [PARAM_FRAC_BITS:0]     t_i,
  input  logic signed [COORD_BITS-1:0] p_i [NUM_CTRL_POINTS],
  output logic [COORD_BITS-1:0]        coord_o
);

  localparam int F   = PARAM_FRAC_BITS;
  localparam int TW  = F + 1;
  localparam int W0  = COORD_BITS;
  localparam int W1  = COORD_BITS + F;
  localparam int W2  = COORD_BITS + 2 * F;
  localparam int W3  = COORD_BITS + 3 * F;
  localparam int P1W = W0 + TW + 2;
  localparam int P2W = W1 + TW + 2;
  localparam int P3W = W2 + TW + 2;

  logic [TW-1:0]        t1_q, t2_q;
  logic signed [TW:0]   ts0, ts1, ts2;
  logic signed [W1-1:0] lv1_d [3];
  logic signed [W1-1:0] lv1_q [3];
  logic signed [W2-1:0] lv2_d [2];
  logic signed [W2-1:0] lv2_q [2];
  logic signed [W3-1:0] lv3_d;
  logic signed [W3-1:0] lv3_q;
  logic signed [W3-1:0] rnd;
  logic [COORD_BITS-1:0] coord_q;

  assign ts0 = $signed({1'b0, t_i});
  assign ts1 = $signed({1'b0, t1_q});
  assign ts2 = $signed({1'b0, t2_q});

  // lerp as a*2^F + (b - a)*t, exact at every level
  for (genvar i = 0; i < 3; i++) begin : g_lv1
    logic signed [W0:0]    d1;
    logic signed [P1W-1:0] a1, m1;
    assign d1 = (W0+1)'(p_i[i+1]) - (W0+1)'(p_i[i]);
    assign a1 = P1W'(p_i[i]);
    assign m1 = d1 * ts0;
    assign lv1_d[i] = W1'((a1 <<< F) + m1);
  end

  for (genvar i = 0; i < 2; i++) begin : g_lv2
    logic signed [W1:0]    d2;
    logic signed [P2W-1:0] a2, m2;
    assign d2 = (W1+1)'(lv1_q[i+1]) - (W1+1)'(lv1_q[i]);
    assign a2 = P2W'(lv1_q[i]);
    assign m2 = d2 * ts1;
    assign lv2_d[i] = W2'((a2 <<< F) + m2);
  end

  logic signed [W2:0]    d3;
  logic signed [P3W-1:0] a3, m3;
  assign d3    = (W2+1)'(lv2_q[1]) - (W2+1)'(lv2_q[0]);
  assign a3    = P3W'(lv2_q[0]);
  assign m3    = d3 * ts2;
  assign lv3_d = W3'((a3 <<< F) + m3);

  // round half up, stays in range since the curve is a convex combination
  assign rnd = lv3_q + (W3'(1) <<< (3 * F - 1));

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      lv1_q <= lv1_d;
      t1_q  <= t_i;
    end
    if (ld_i.s2) begin
      lv2_q <= lv2_d;
      t2_q  <= t1_q;
    end
    if (ld_i.s3) begin
      lv3_q <= lv3_d;
    end
    if (ld_i.s4) begin
      coord_q <= rnd[3 * F +: COORD_BITS];
    end
  end

  assign coord_o = coord_q;

endmodule

### design/cubic_bezier_point_eval_top.sv
// top level of the cubic bezier point evaluator
// pipeline: five register stages, the parameter, three lerp levels and the rounded point
// throughput: one point per cycle while the output is ready; each stage has its own enable so bubbles collapse
// the deepest path per stage is one lerp multiply by t plus a wide add
// reset: asynchronous active low, clears all valid bits and the four control points
// control points are written through the config channel, which is always ready
module cubic_bezier_point_eval_top import cbez_pkg::*; #(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [REG_W-1:0]       cfg_data_i,
  // parameter stream in
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [16:0] param_t, rest zero
  // curve point stream out
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [15:0] point_x, [31:16] point_y, [47:32] point_z
);

  localparam int TW      = PARAM_FRAC_BITS + 1;
  localparam int PIDX_W  = $clog2(NUM_CTRL_POINTS);
  localparam int EXT_W   = (NUM_AXES * COORD_BITS > REG_W) ? NUM_AXES * COORD_BITS : REG_W;
  localparam int NSTAGES = 5;

  localparam logic [TW-1:0] T_ONE = TW'(1) << PARAM_FRAC_BITS;

  // control point registers
  logic [REG_W-1:0] ctrl_q [NUM_CTRL_POINTS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CTRL_POINTS; k++) begin
        ctrl_q[k] <= '0;
      end
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_W'(NUM_CTRL_POINTS))) begin
      // indexes past the last control point are dropped
      ctrl_q[cfg_index_i[PIDX_W-1:0]] <= cfg_data_i;
    end
  end

  // coordinates above the register width read as zero
  logic [EXT_W-1:0]             ctrl_ext [NUM_CTRL_POINTS];
  logic signed [COORD_BITS-1:0] pts [NUM_AXES][NUM_CTRL_POINTS];

  for (genvar k = 0; k < NUM_CTRL_POINTS; k++) begin : g_ext
    assign ctrl_ext[k] = EXT_W'(ctrl_q[k]);
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis_sel
      assign pts[a][k] = $signed(ctrl_ext[k][a * COORD_BITS +: COORD_BITS]);
    end
  end

  // stage valid bits and per-stage enables, a stage moves when empty or when
  // its successor moves
  logic [NSTAGES-1:0] vld_q;
  logic [NSTAGES-1:0] vld_in;
  logic [NSTAGES:0]   en;

  assign vld_in = {vld_q[NSTAGES-2:0], s_axis_tvalid};

  always_comb begin
    en[NSTAGES] = m_axis_tready;
    for (int k = NSTAGES - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NSTAGES-1];

  // input stage: parameter width fit and saturation to one
  logic [TW-1:0] t_raw, t0_d, t0_q;

  assign t_raw = TW'(s_axis_tdata[PARAM_T_W-1:0]);
  assign t0_d  = (t_raw > T_ONE) ? T_ONE : t_raw;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      t0_q <= t0_d;
    end
  end

  // one datapath per axis, all sharing the stage enables
  cbez_ld_t ld;

  assign ld.s1 = en[1];
  assign ld.s2 = en[2];
  assign ld.s3 = en[3];
  assign ld.s4 = en[4];

  logic [COORD_BITS-1:0] coord [NUM_AXES];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    cbez_axis #(
      .COORD_BITS     (COORD_BITS),
      .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
    ) u_axis (
      .clk_i  (clk_i),
      .ld_i   (ld),
      .t_i    (t0_q),
      .p_i    (pts[a]),
      .coord_o(coord[a])
    );
    assign m_axis_tdata[a * POINT_W +: POINT_W] = POINT_W'(coord[a]);
  end

  // a draining output never blocks the input
  a_drain_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  // input is only refused when every stage holds an item
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&vld_q))
    else $error("input stalled with a bubble in the pipeline");

  // an item in the last lerp stage reaches the output when it is free
  a_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NSTAGES-2] && en[NSTAGES-1]) |=> m_axis_tvalid)
    else $error("item lost between last lerp and output");

  // the registered parameter never exceeds one
  a_t_clamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (t0_q <= T_ONE))
    else $error("parameter above one in the pipeline");

endmodule
